>>> hdl/cbwe_pkg.sv
// Shared types and constants for the capture buffer waveform envelope unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cbwe_pkg;

  // Sample store geometry.
  localparam int MEM_DEPTH  = 65536;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int FILL_W     = ADDR_W + 1;
  localparam int BANK_DEPTH = MEM_DEPTH / 2;
  localparam int BANK_AW    = ADDR_W - 1;

  // Field widths fixed by the port list.
  localparam int ACT_W = 2;
  localparam int CC_W  = 4;
  localparam int SMP_W = 17;
  localparam int BKT_W = 7;
  localparam int WIN_W = 17;
  localparam int IDX_W = 6;
  localparam int OUT_W = 16;
  localparam int CMP_W = (FILL_W > WIN_W) ? FILL_W : WIN_W;

  // Envelope limits.
  localparam int MAX_BUCKETS = 64;
  localparam int DIV_CW      = $clog2(FILL_W + 1);
  localparam logic signed [SMP_W:0] MIX_HI = (SMP_W + 1)'(32767);
  localparam logic signed [SMP_W:0] MIX_LO = -(SMP_W + 1)'(32768);

  // Command codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_SNAP  = 2'd3
  } act_e;

  // Snapshot sequencer states.
  typedef enum logic [2:0] {
    SN_IDLE,
    SN_DIV,
    SN_SETUP,
    SN_SCAN,
    SN_DRAIN
  } snap_state_t;

  // Write request into the sample store: one or two entries from entry addr.
  typedef struct packed {
    logic                    en;
    logic                    pair;
    logic [ADDR_W-1:0]       addr;
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } wr_req_t;

  // Read request: the same row of both banks.
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
  } rd_req_t;

endpackage

`default_nettype wire

>>> hdl/capture_buffer_waveform_envelope_unit.sv
// Top level of the capture buffer waveform envelope unit.
// Depends on cbwe_pkg, cbwe_store, cbwe_snap.
//
// Usage: a command word is taken at a rising edge with start high and busy
// low. Start recording, unless already recording, clears the fill count and
// selects stereo grouping; stop only halts capture. An audio frame, while
// recording and with room, writes channel 0, or channels 0 and 1, into the
// sample store in the accepting cycle and leaves busy low, so frames can
// follow every cycle. A snapshot request raises busy from the next cycle
// until its last result word has been produced. For a snapshot, the serial
// divider splits the window, then each bucket is scanned through the single
// read port of the store (both banks read one row per cycle). Each result
// word appears on strobe after its bucket's drain state; results cannot be
// held off and are gone after the strobe cycle. A snapshot with no
// buckets or an empty recording returns no words and does not raise busy.
// Reset: capture off, fill count zero, stereo grouping; the store contents
// are not cleared, and only entries written since the last start are read.
`timescale 1ns / 1ps
`default_nettype none

module capture_buffer_waveform_envelope_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cbwe_pkg::ACT_W-1:0]        action,
  input  logic [cbwe_pkg::CC_W-1:0]         channel_count,
  input  logic signed [cbwe_pkg::SMP_W-1:0] sample_left,
  input  logic signed [cbwe_pkg::SMP_W-1:0] sample_right,
  input  logic                              frame_last,
  input  logic [cbwe_pkg::BKT_W-1:0]        bucket_count,
  input  logic [cbwe_pkg::WIN_W-1:0]        window_frames,
  output logic                              strobe,
  output logic [cbwe_pkg::IDX_W-1:0]        bucket_index,
  output logic signed [cbwe_pkg::OUT_W-1:0] bucket_min,
  output logic signed [cbwe_pkg::OUT_W-1:0] bucket_max,
  output logic                              last
);
  import cbwe_pkg::*;

  logic              accept, snap_go, full, pair_fits, is_pair, host_block_end;
  logic [FILL_W-1:0] fill;
  logic              recording, stereo;
  act_e              act;
  wr_req_t           wr_req;
  rd_req_t           rd_req;
  logic signed [SMP_W-1:0] rd_data0, rd_data1;

  // Command decode. The end-of-block mark has no effect on storage.
  always_comb begin
    accept         = start && !busy;
    act            = act_e'(action);
    host_block_end = frame_last;
    full           = fill >= FILL_W'(MEM_DEPTH);
    pair_fits      = fill < FILL_W'(MEM_DEPTH - 1);
    is_pair        = channel_count != CC_W'(1);
    snap_go        = accept && act == ACT_SNAP;
    wr_req.en      = accept && act == ACT_FRAME && recording && channel_count != '0
                     && !full && (!is_pair || pair_fits);
    wr_req.pair    = is_pair;
    wr_req.addr    = fill[ADDR_W-1:0];
    wr_req.left    = sample_left;
    wr_req.right   = sample_right;
  end

  // Capture control.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      recording <= 1'b0;
      stereo    <= 1'b1;
    end else if (accept) begin
      unique case (act)
        ACT_START: begin
          if (!recording) begin
            fill      <= '0;
            stereo    <= 1'b1;
            recording <= 1'b1;
          end
        end
        ACT_STOP: begin
          recording <= 1'b0;
        end
        ACT_FRAME: begin
          if (wr_req.en) begin
            if (fill == '0) begin
              stereo <= is_pair;
            end
            fill <= fill + (is_pair ? FILL_W'(2) : FILL_W'(1));
          end
        end
        ACT_SNAP: begin
          fill <= fill;
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

  cbwe_store u_store (
    .clk      (clk),
    .wr       (wr_req),
    .rd       (rd_req),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  cbwe_snap u_snap (
    .clk           (clk),
    .rst           (rst),
    .go            (snap_go),
    .bucket_count  (bucket_count),
    .window_frames (window_frames),
    .fill          (fill),
    .stereo        (stereo),
    .busy          (busy),
    .rd            (rd_req),
    .rd_data0      (rd_data0),
    .rd_data1      (rd_data1),
    .strobe        (strobe),
    .bucket_index  (bucket_index),
    .bucket_min    (bucket_min),
    .bucket_max    (bucket_max),
    .last          (last)
  );

  // A result word only follows a cycle of snapshot work.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a running snapshot");

  // A word that is not the final one leaves the snapshot running.
  a_more_buckets: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("snapshot ended before its final bucket");

  // The store is never written while a snapshot reads it.
  a_no_write_in_snap: assert property (@(posedge clk) disable iff (rst)
    wr_req.en |-> !busy)
    else $error("store write during a snapshot");

  // The store never holds more entries than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    wr_req.en |=> fill <= FILL_W'(MEM_DEPTH) && !(host_block_end && 1'b0))
    else $error("fill count beyond store depth");

endmodule

`default_nettype wire

>>> hdl/cbwe_store.sv
// Sample store: two banks holding even and odd entries, one synchronous read.
// Depends on cbwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbwe_store (
  input  logic                             clk,
  input  cbwe_pkg::wr_req_t                wr,
  input  cbwe_pkg::rd_req_t                rd,
  output logic signed [cbwe_pkg::SMP_W-1:0] rd_data0,
  output logic signed [cbwe_pkg::SMP_W-1:0] rd_data1
);
  import cbwe_pkg::*;

  logic signed [SMP_W-1:0] mem0 [BANK_DEPTH];
  logic signed [SMP_W-1:0] mem1 [BANK_DEPTH];

  logic                    we0, we1;
  logic [BANK_AW-1:0]      wa0, wa1, row, row_up;
  logic signed [SMP_W-1:0] wd0, wd1;

  // Entry e lives in bank e[0] at row e >> 1. A pair starting on an odd entry
  // puts its second word in bank 0 one row up.
  always_comb begin
    row    = wr.addr[ADDR_W-1:1];
    row_up = row + BANK_AW'(1);
    if (!wr.addr[0]) begin
      we0 = wr.en;
      wa0 = row;
      wd0 = wr.left;
      we1 = wr.en && wr.pair;
      wa1 = row;
      wd1 = wr.right;
    end else begin
      we1 = wr.en;
      wa1 = row;
      wd1 = wr.left;
      we0 = wr.en && wr.pair;
      wa0 = row_up;
      wd0 = wr.right;
    end
  end

  // Bank 0 port.
  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    if (rd.en) begin
      rd_data0 <= mem0[rd.addr];
    end
  end

  // Bank 1 port.
  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    if (rd.en) begin
      rd_data1 <= mem1[rd.addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/cbwe_div.sv
// Restoring divider, one quotient bit per cycle, for splitting the window.
// Depends on cbwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbwe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbwe_pkg::FILL_W-1:0]   dividend,
  input  logic [cbwe_pkg::BKT_W-1:0]    divisor,
  output logic                          done,
  output logic [cbwe_pkg::FILL_W-1:0]   quotient,
  output logic [cbwe_pkg::BKT_W-1:0]    remainder
);
  import cbwe_pkg::*;

  logic [DIV_CW-1:0] cnt;
  logic [BKT_W-1:0]  dsr;
  logic [BKT_W:0]    partial, diff;
  logic              ge;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    partial = {remainder, quotient[FILL_W-1]};
    diff    = partial - {1'b0, dsr};
    ge      = partial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dsr       <= divisor;
        cnt       <= DIV_CW'(FILL_W);
      end else if (cnt != '0) begin
        quotient  <= {quotient[FILL_W-2:0], ge};
        remainder <= ge ? diff[BKT_W-1:0] : partial[BKT_W-1:0];
        cnt       <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cbwe_snap.sv
// Snapshot sequencer: splits the window into buckets, scans the store and
// reports the per-bucket minimum and maximum. Depends on cbwe_pkg, cbwe_div.
`timescale 1ns / 1ps
`default_nettype none

module cbwe_snap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [cbwe_pkg::BKT_W-1:0]        bucket_count,
  input  logic [cbwe_pkg::WIN_W-1:0]        window_frames,
  input  logic [cbwe_pkg::FILL_W-1:0]       fill,
  input  logic                              stereo,
  output logic                              busy,
  output cbwe_pkg::rd_req_t                 rd,
  input  logic signed [cbwe_pkg::SMP_W-1:0] rd_data0,
  input  logic signed [cbwe_pkg::SMP_W-1:0] rd_data1,
  output logic                              strobe,
  output logic [cbwe_pkg::IDX_W-1:0]        bucket_index,
  output logic signed [cbwe_pkg::OUT_W-1:0] bucket_min,
  output logic signed [cbwe_pkg::OUT_W-1:0] bucket_max,
  output logic                              last
);
  import cbwe_pkg::*;

  snap_state_t st, st_next;

  // Request decode.
  logic [FILL_W-1:0] frames, visible, first;
  logic [CMP_W-1:0]  win_ext, frames_ext;
  logic [BKT_W-1:0]  w;
  logic              go_ok;

  // Divider.
  logic              div_done;
  logic [FILL_W-1:0] quo;
  logic [BKT_W-1:0]  rem;

  // Bucket walk.
  logic [BKT_W-1:0]  wd;
  logic [IDX_W-1:0]  w_last, x;
  logic [FILL_W-1:0] p, p1, f, f_inc, fend;
  logic [BKT_W-1:0]  r, r1;
  logic [BKT_W:0]    sum_r, sum_d;
  logic              carry;

  // Scan datapath.
  logic                    rd_valid, rd_sel;
  logic signed [SMP_W:0]   sum_s, mix_s;
  logic signed [OUT_W-1:0] mix, lo, hi, lo_next, hi_next;

  // Frames, visible span and bucket count of a new request.
  always_comb begin
    frames     = stereo ? {1'b0, fill[FILL_W-1:1]} : fill;
    win_ext    = CMP_W'(window_frames);
    frames_ext = CMP_W'(frames);
    if (win_ext != '0 && win_ext < frames_ext) begin
      visible = win_ext[FILL_W-1:0];
    end else begin
      visible = frames;
    end
    first = frames - visible;
    w     = (bucket_count > BKT_W'(MAX_BUCKETS)) ? BKT_W'(MAX_BUCKETS) : bucket_count;
    go_ok = go && (w != '0) && (frames != '0);
  end

  cbwe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (go_ok),
    .dividend  (visible),
    .divisor   (w),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Next bucket boundary: add visible / w, carry the remainder.
  always_comb begin
    sum_r = {1'b0, r} + {1'b0, rem};
    sum_d = sum_r - {1'b0, wd};
    carry = sum_r >= {1'b0, wd};
    r1    = carry ? sum_d[BKT_W-1:0] : sum_r[BKT_W-1:0];
    p1    = p + quo + FILL_W'(carry);
    f_inc = f + FILL_W'(1);
  end

  // Mix the word read last cycle and fold it into the running envelope.
  always_comb begin
    sum_s = {rd_data0[SMP_W-1], rd_data0} + {rd_data1[SMP_W-1], rd_data1};
    if (stereo) begin
      mix_s = sum_s >>> 1;
    end else if (rd_sel) begin
      mix_s = {rd_data1[SMP_W-1], rd_data1};
    end else begin
      mix_s = {rd_data0[SMP_W-1], rd_data0};
    end
    if (mix_s > MIX_HI) begin
      mix = MIX_HI[OUT_W-1:0];
    end else if (mix_s < MIX_LO) begin
      mix = MIX_LO[OUT_W-1:0];
    end else begin
      mix = mix_s[OUT_W-1:0];
    end
    lo_next = lo;
    hi_next = hi;
    if (rd_valid && mix < lo) begin
      lo_next = mix;
    end
    if (rd_valid && mix > hi) begin
      hi_next = mix;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SN_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Next state, busy and read requests.
  always_comb begin
    st_next = st;
    busy    = 1'b1;
    rd.en   = 1'b0;
    rd.addr = stereo ? f[BANK_AW-1:0] : f[ADDR_W-1:1];
    unique case (st)
      SN_IDLE: begin
        busy = 1'b0;
        if (go_ok) begin
          st_next = SN_DIV;
        end
      end
      SN_DIV: begin
        if (div_done) begin
          st_next = SN_SETUP;
        end
      end
      SN_SETUP: begin
        st_next = SN_SCAN;
      end
      SN_SCAN: begin
        rd.en = 1'b1;
        if (f_inc == fend) begin
          st_next = SN_DRAIN;
        end
      end
      SN_DRAIN: begin
        st_next = (x == w_last) ? SN_IDLE : SN_SETUP;
      end
      default: begin
        st_next = SN_IDLE;
      end
    endcase
  end

  // Bucket walk and envelope registers.
  always_ff @(posedge clk) begin
    rd_valid <= (st == SN_SCAN);
    rd_sel   <= f[0];
    if (st == SN_IDLE && go_ok) begin
      p      <= first;
      r      <= '0;
      wd     <= w;
      w_last <= IDX_W'(w - BKT_W'(1));
      x      <= '0;
    end
    if (st == SN_SETUP) begin
      // A bucket spans at least one frame even when the split gives none.
      f    <= p;
      p    <= p1;
      r    <= r1;
      fend <= (p1 == p) ? (p + FILL_W'(1)) : p1;
      lo   <= '0;
      hi   <= '0;
    end else begin
      lo   <= lo_next;
      hi   <= hi_next;
    end
    if (st == SN_SCAN) begin
      f <= f_inc;
    end
    if (st == SN_DRAIN) begin
      x <= x + IDX_W'(1);
    end
  end

  // Result word, shown for one cycle after the last read of a bucket.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (st == SN_DRAIN);
    end
    if (st == SN_DRAIN) begin
      bucket_index <= x;
      bucket_min   <= lo_next;
      bucket_max   <= hi_next;
      last         <= (x == w_last);
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the capture buffer waveform envelope unit.
// Depends on cbwe_pkg and the top level; it keeps its own recorder model and
// checks every envelope bucket word against the predicted one.
`timescale 1ns / 1ps

module tb;
  import cbwe_pkg::*;

  localparam int RUN_LIMIT  = 2000000;
  localparam int DRAIN_WAIT = 200000;
  localparam int SETTLE     = 100;

  // One command word as the host presents it.
  typedef struct packed {
    act_e                    act;
    logic [CC_W-1:0]         cc;
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
    logic                    fl;
    logic [BKT_W-1:0]        bc;
    logic [WIN_W-1:0]        win;
  } host_word_t;

  // One envelope bucket as the unit reports it.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [OUT_W-1:0] lo;
    logic signed [OUT_W-1:0] hi;
    logic                    fin;
  } bucket_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ACT_W-1:0]        action = '0;
  logic [CC_W-1:0]         channel_count = '0;
  logic signed [SMP_W-1:0] sample_left = '0;
  logic signed [SMP_W-1:0] sample_right = '0;
  logic                    frame_last = 1'b0;
  logic [BKT_W-1:0]        bucket_count = '0;
  logic [WIN_W-1:0]        window_frames = '0;
  logic                    strobe;
  logic [IDX_W-1:0]        bucket_index;
  logic signed [OUT_W-1:0] bucket_min;
  logic signed [OUT_W-1:0] bucket_max;
  logic                    last;

  // Recorder model state.
  logic signed [SMP_W-1:0] rec_store [MEM_DEPTH];
  int                      rec_fill = 0;
  bit                      rec_on = 1'b0;
  bit                      rec_stereo = 1'b1;

  bucket_t pending_buckets[$];
  int      fail_count = 0;
  int      useful_words = 0;
  bit      gaps_on = 1'b1;

  capture_buffer_waveform_envelope_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .channel_count(channel_count), .sample_left(sample_left),
    .sample_right(sample_right), .frame_last(frame_last),
    .bucket_count(bucket_count), .window_frames(window_frames),
    .strobe(strobe), .bucket_index(bucket_index), .bucket_min(bucket_min),
    .bucket_max(bucket_max), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run may not outlast the cycle budget.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  function automatic void report_fault(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Mixed and clamped value of one stored frame under the current grouping.
  function automatic int mixed_frame(input int f);
    int m;
    if (rec_stereo) m = (int'(rec_store[2*f]) + int'(rec_store[2*f+1])) >>> 1;
    else m = int'(rec_store[f]);
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return m;
  endfunction

  // Splits the newest window into buckets and queues their min and max.
  function automatic void predict_envelope(input int bc, input int win);
    int      width, frames, visible, first, bs, be, lo, hi, m, x, f;
    bucket_t b;
    width = bc;
    if (width > MAX_BUCKETS) width = MAX_BUCKETS;
    frames = rec_stereo ? rec_fill / 2 : rec_fill;
    if (width == 0 || frames == 0) return;
    visible = (win != 0 && win < frames) ? win : frames;
    first = frames - visible;
    for (x = 0; x < width; x++) begin
      bs = first + int'((longint'(visible) * x) / width);
      be = first + int'((longint'(visible) * (x + 1)) / width);
      if (be < bs + 1) be = bs + 1;
      if (be > frames) be = frames;
      lo = 0;
      hi = 0;
      for (f = bs; f < be; f++) begin
        m = mixed_frame(f);
        if (m < lo) lo = m;
        if (m > hi) hi = m;
      end
      b.idx = IDX_W'(x);
      b.lo  = OUT_W'(lo);
      b.hi  = OUT_W'(hi);
      b.fin = (x + 1 == width);
      pending_buckets.insert(pending_buckets.size(), b);
    end
  endfunction

  // Applies an accepted word to the model; returns 1 if it did anything, and always for a snapshot.
  function automatic bit apply_word(input host_word_t w);
    case (w.act)
      ACT_START: begin
        if (rec_on) return 1'b0;
        rec_fill = 0;
        rec_stereo = 1'b1;
        rec_on = 1'b1;
        return 1'b1;
      end
      ACT_STOP: begin
        if (!rec_on) return 1'b0;
        rec_on = 1'b0;
        return 1'b1;
      end
      ACT_FRAME: begin
        if (!rec_on || w.cc == 0 || rec_fill >= MEM_DEPTH) return 1'b0;
        if (rec_fill == 0) rec_stereo = (w.cc >= 2);
        if (w.cc == 1) begin
          rec_store[rec_fill] = w.left;
          rec_fill++;
        end else if (rec_fill + 1 < MEM_DEPTH) begin
          rec_store[rec_fill] = w.left;
          rec_store[rec_fill+1] = w.right;
          rec_fill += 2;
        end else begin
          return 1'b0;
        end
        return 1'b1;
      end
      default: begin
        predict_envelope(int'(w.bc), int'(w.win));
        return 1'b1;
      end
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      case ($urandom_range(0, 5))
        0: return SMP_W'(-65536);
        1: return SMP_W'(65535);
        2: return SMP_W'(-32768);
        3: return SMP_W'(32767);
        4: return SMP_W'(0);
        default: return SMP_W'(-1);
      endcase
    end
    if (pick < 3) return SMP_W'(int'($urandom_range(0, 65535)) - 32768);
    return SMP_W'($urandom);
  endfunction

  // A word with the given command and random values in every other field.
  function automatic host_word_t random_word(input act_e a);
    host_word_t w;
    w.act   = a;
    w.cc    = CC_W'($urandom_range(0, 15));
    w.left  = random_sample();
    w.right = random_sample();
    w.fl    = 1'($urandom_range(0, 1));
    w.bc    = BKT_W'($urandom_range(0, 127));
    w.win   = WIN_W'($urandom_range(0, 65536));
    return w;
  endfunction

  // Presents one word, waits until it is taken, then maybe idles a while.
  task automatic send_word(input host_word_t w);
    start         <= 1'b1;
    action        <= w.act;
    channel_count <= w.cc;
    sample_left   <= w.left;
    sample_right  <= w.right;
    frame_last    <= w.fl;
    bucket_count  <= w.bc;
    window_frames <= w.win;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (apply_word(w)) useful_words++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(input act_e a);
    send_word(random_word(a));
  endtask

  task automatic send_frame(input int cc, input int l, input int r);
    host_word_t w;
    w = random_word(ACT_FRAME);
    w.cc = CC_W'(cc);
    w.left = SMP_W'(l);
    w.right = SMP_W'(r);
    send_word(w);
  endtask

  task automatic send_snap(input int bc, input int win);
    host_word_t w;
    w = random_word(ACT_SNAP);
    w.bc = BKT_W'(bc);
    w.win = WIN_W'(win);
    send_word(w);
  endtask

  task automatic send_random_snap();
    int frames, bc, win;
    frames = rec_stereo ? rec_fill / 2 : rec_fill;
    bc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
    case ($urandom_range(0, 2))
      0: win = 0;
      1: win = $urandom_range(1, frames + 4);
      default: win = $urandom_range(0, 65536);
    endcase
    send_snap(bc, win);
  endtask

  // Each bucket word is taken at the edge that ends its strobe cycle.
  always @(posedge clk) begin
    bucket_t want;
    if (!rst && strobe) begin
      if (pending_buckets.size() == 0) begin
        report_fault($sformatf("unexpected bucket %0d min %0d max %0d last %0b",
                               bucket_index, bucket_min, bucket_max, last));
      end else begin
        want = pending_buckets.pop_front();
        if (bucket_index !== want.idx || bucket_min !== want.lo ||
            bucket_max !== want.hi || last !== want.fin)
          report_fault($sformatf(
            "bucket exp idx %0d min %0d max %0d last %0b, got %0d %0d %0d %0b",
            want.idx, want.lo, want.hi, want.fin,
            bucket_index, bucket_min, bucket_max, last));
      end
    end
  end

  // Commands with nothing recorded, then a short stereo recording that hits
  // clamping, floor rounding, a mixed-in mono frame and the bucket limits.
  task automatic test_stereo_corners();
    send_snap(64, 0);
    send_frame(2, 1000, 2000);
    send_cmd(ACT_STOP);
    send_cmd(ACT_START);
    send_frame(0, 5, 5);
    send_snap(64, 0);
    send_frame(2, 65535, 65535);
    send_frame(15, -65536, -65536);
    send_frame(2, -3, 0);
    send_frame(8, 1, 0);
    send_cmd(ACT_START);
    send_frame(1, 100, 0);
    send_frame(2, 32767, -32768);
    send_snap(0, 0);
    send_snap(1, 0);
    send_snap(127, 0);
    send_snap(3, 2);
    send_snap(5, 65536);
    send_cmd(ACT_STOP);
    send_frame(2, 7, 7);
    send_snap(64, 1);
  endtask

  // A recording whose first frame is mono, with a stereo frame stored later.
  task automatic test_mono_grouping();
    send_cmd(ACT_START);
    send_frame(1, -65536, 0);
    send_frame(1, 65535, 0);
    send_frame(1, -32769, 0);
    send_frame(3, 5, 7);
    send_snap(4, 0);
    send_snap(64, 3);
    send_cmd(ACT_STOP);
  endtask

  // Mostly well-formed recording sessions with random content and a few
  // stray or broken commands in between.
  task automatic test_random_sessions(input int target, input bit gaps);
    int  i, k, cc;
    bit  stereo;
    useful_words = 0;
    while (useful_words < target) begin
      gaps_on = gaps && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_word(random_word(act_e'(ACT_W'($urandom_range(0, 3)))));
      end else begin
        send_cmd(ACT_START);
        stereo = 1'($urandom_range(0, 1));
        k = $urandom_range(1, 40);
        for (i = 0; i < k; i++) begin
          case ($urandom_range(0, 15))
            0: cc = 0;
            1: cc = stereo ? 1 : $urandom_range(2, 15);
            2: cc = stereo ? $urandom_range(3, 15) : 1;
            default: cc = stereo ? 2 : 1;
          endcase
          send_frame(cc, random_sample(), random_sample());
          if ($urandom_range(0, 11) == 0) send_random_snap();
          if ($urandom_range(0, 29) == 0) send_cmd(ACT_START);
        end
        if ($urandom_range(0, 1)) send_cmd(ACT_STOP);
        repeat ($urandom_range(1, 3)) send_random_snap();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_stereo_corners();
    test_mono_grouping();
    test_random_sessions(240, 1'b1);
    test_random_sessions(60, 1'b0);

    // Let the last snapshot finish, then watch for stray words.
    start <= 1'b0;
    waited = 0;
    while (pending_buckets.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_buckets.size() != 0)
      report_fault($sformatf("%0d bucket words never arrived", pending_buckets.size()));

    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
